// ===== design/rbfk_pkg.sv =====
// rbfk_pkg: shared types, register indexes and constant functions for the
// squared-exponential kernel block (controller, datapath and top level).
// No dependencies.
package rbfk_pkg;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INV   = CFG_IDX_W'(1);
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	// coordinate slots on the ports and width of a dimension index
	localparam int MAX_DIM = 3;
	localparam int DIM_W   = 2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_WB, ST_ROM_A, ST_ROM_B, ST_EMIT
	} st_t;

	// multiply operations of the shared multiplier
	typedef enum logic [3:0] {
		OP_SQ, OP_XHI, OP_XLO, OP_INTERP, OP_K, OP_IK, OP_G, OP_DD, OP_PM, OP_TM
	} op_t;

	// entry kinds, same codes as the entry_kind port
	typedef enum logic [1:0] {
		KIND_VV = 2'd0, KIND_VG = 2'd1, KIND_GV = 2'd2, KIND_GG = 2'd3
	} kind_t;

	typedef struct packed {
		logic             load;
		op_t              op;
		logic             issue;
		logic [1:0]       part;
		logic             accum;
		logic             first;
		logic             wb;
		logic             rom_a;
		logic             rom_b;
		logic             emit;
		kind_t            kind;
		logic [DIM_W-1:0] i;
		logic [DIM_W-1:0] j;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic grad_a;
		logic grad_b;
		logic out_free;
	} status_t;

	// exp(-h) in Q1.31 from a truncated alternating Taylor series
	function automatic logic [63:0] exp_base(input logic [63:0] h);
		logic [63:0] term;
		logic signed [63:0] sum;
		term = 64'd1 << 31;
		sum  = $signed(term);
		term = ((term * h) >> 31) / 64'd1;  sum = sum - $signed(term);
		term = ((term * h) >> 31) / 64'd2;  sum = sum + $signed(term);
		term = ((term * h) >> 31) / 64'd3;  sum = sum - $signed(term);
		term = ((term * h) >> 31) / 64'd4;  sum = sum + $signed(term);
		term = ((term * h) >> 31) / 64'd5;  sum = sum - $signed(term);
		term = ((term * h) >> 31) / 64'd6;  sum = sum + $signed(term);
		term = ((term * h) >> 31) / 64'd7;  sum = sum - $signed(term);
		term = ((term * h) >> 31) / 64'd8;  sum = sum + $signed(term);
		term = ((term * h) >> 31) / 64'd9;  sum = sum - $signed(term);
		term = ((term * h) >> 31) / 64'd10; sum = sum + $signed(term);
		term = ((term * h) >> 31) / 64'd11; sum = sum - $signed(term);
		term = ((term * h) >> 31) / 64'd12; sum = sum + $signed(term);
		term = ((term * h) >> 31) / 64'd13; sum = sum - $signed(term);
		term = ((term * h) >> 31) / 64'd14; sum = sum + $signed(term);
		term = ((term * h) >> 31) / 64'd15; sum = sum - $signed(term);
		if (sum < 0) begin
			sum = '0;
		end
		return sum;
	endfunction

	// table entry n in Q2.30: n rounded steps of the base factor
	function automatic logic [30:0] exp_entry(input logic [63:0] base, input int n);
		logic [63:0] t;
		t = 64'd1 << 30;
		for (int k = 0; k < n; k++) begin
			t = (t * base + (64'd1 << 30)) >> 31;
		end
		return t[30:0];
	endfunction

	// sign a magnitude and saturate to the int32 range
	function automatic logic [31:0] sat_entry(input logic [31:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = mag[31] ? 32'h8000_0000 : (32'd0 - mag);
		end else begin
			r = mag[31] ? 32'h7FFF_FFFF : mag;
		end
		return r;
	endfunction

endpackage

// ===== design/rbfk_ctrl.sv =====
// rbfk_ctrl: sequencer for the kernel datapath; walks the multiply schedule
// and the entry list of one pair. Depends on rbfk_pkg.
module rbfk_ctrl #(
	parameter int DIM = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rbfk_pkg::status_t status,
	output rbfk_pkg::cmd_t    cmd
);
	import rbfk_pkg::*;

	localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(DIM - 1);

	st_t              state_q, state_d;
	op_t              op_q, op_d;
	kind_t            kind_q, kind_d;
	logic [DIM_W-1:0] i_q, i_d, j_q, j_d;
	logic [2:0]       ph_q, ph_d;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SQ;
			kind_q  <= KIND_VV;
			i_q     <= '0;
			j_q     <= '0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			kind_q  <= kind_d;
			i_q     <= i_d;
			j_q     <= j_d;
			ph_q    <= ph_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		kind_d  = kind_q;
		i_d     = i_q;
		j_d     = j_q;
		ph_d    = ph_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MUL;
					op_d    = OP_SQ;
					i_d     = '0;
					j_d     = '0;
					ph_d    = '0;
				end
			end
			ST_MUL: begin
				if (ph_q == 3'd4) begin
					ph_d    = '0;
					state_d = ST_WB;
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			ST_WB: begin
				state_d = ST_MUL;
				unique case (op_q)
					OP_SQ: begin
						if (i_q == LAST_DIM) begin
							op_d = OP_XHI;
							i_d  = '0;
						end else begin
							i_d = i_q + 1'b1;
						end
					end
					OP_XHI:    op_d = OP_XLO;
					OP_XLO:    state_d = ST_ROM_A;
					OP_INTERP: op_d = OP_K;
					OP_K:      op_d = OP_IK;
					OP_IK: begin
						state_d = ST_EMIT;
						kind_d  = KIND_VV;
					end
					OP_G: begin
						if (i_q == LAST_DIM) begin
							state_d = ST_EMIT;
							i_d     = '0;
							kind_d  = status.grad_b ? KIND_VG : KIND_GV;
						end else begin
							i_d = i_q + 1'b1;
						end
					end
					OP_DD: op_d = OP_PM;
					OP_PM: op_d = OP_TM;
					OP_TM: begin
						state_d = ST_EMIT;
						kind_d  = KIND_GG;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_ROM_A: state_d = ST_ROM_B;
			ST_ROM_B: begin
				state_d = ST_MUL;
				op_d    = OP_INTERP;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					unique case (kind_q)
						KIND_VV: begin
							if (status.grad_a || status.grad_b) begin
								state_d = ST_MUL;
								op_d    = OP_G;
								i_d     = '0;
							end else begin
								state_d = ST_IDLE;
							end
						end
						KIND_VG: begin
							if (i_q == LAST_DIM) begin
								i_d = '0;
								if (status.grad_a) begin
									kind_d = KIND_GV;
								end else begin
									state_d = ST_IDLE;
								end
							end else begin
								i_d = i_q + 1'b1;
							end
						end
						KIND_GV: begin
							if (i_q == LAST_DIM) begin
								i_d = '0;
								j_d = '0;
								if (status.grad_b) begin
									state_d = ST_MUL;
									op_d    = OP_DD;
								end else begin
									state_d = ST_IDLE;
								end
							end else begin
								i_d = i_q + 1'b1;
							end
						end
						KIND_GG: begin
							if (j_q == LAST_DIM) begin
								j_d = '0;
								if (i_q == LAST_DIM) begin
									state_d = ST_IDLE;
								end else begin
									i_d     = i_q + 1'b1;
									state_d = ST_MUL;
									op_d    = OP_DD;
								end
							end else begin
								j_d     = j_q + 1'b1;
								state_d = ST_MUL;
								op_d    = OP_DD;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		cmd.op   = op_q;
		cmd.kind = kind_q;
		cmd.i    = i_q;
		cmd.j    = j_q;
		in_stall = 1'b1;
		unique case (kind_q)
			KIND_VV: cmd.last = !(status.grad_a || status.grad_b);
			KIND_VG: cmd.last = (i_q == LAST_DIM) && !status.grad_a;
			KIND_GV: cmd.last = (i_q == LAST_DIM) && !status.grad_b;
			KIND_GG: cmd.last = (i_q == LAST_DIM) && (j_q == LAST_DIM);
			default: cmd.last = 1'b0;
		endcase
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL: begin
				cmd.issue = !ph_q[2];
				cmd.part  = ph_q[1:0];
				cmd.accum = (ph_q != 3'd0);
				cmd.first = (ph_q == 3'd1);
			end
			ST_WB:    cmd.wb = 1'b1;
			ST_ROM_A: cmd.rom_a = 1'b1;
			ST_ROM_B: cmd.rom_b = 1'b1;
			ST_EMIT:  cmd.emit = status.out_free;
			default:  cmd.wb = 1'b0;
		endcase
	end

	a_phase_only_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MUL) |-> (ph_q == 3'd0))
		else $error("multiply phase counter running outside a multiply");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(i_q <= LAST_DIM) && (j_q <= LAST_DIM))
		else $error("dimension index beyond DIM");

	a_load_starts_squares: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_MUL) && (op_q == OP_SQ) && (i_q == '0))
		else $error("accepted request did not start the distance pass");

	a_cross_needs_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && (kind_q == KIND_GG) |-> status.grad_a && status.grad_b)
		else $error("cross entry emitted without both gradient flags");

endmodule

// ===== design/rbfk_datapath.sv =====
// rbfk_datapath: operand registers, shared 32x32 multiplier with partial
// product accumulator, exp table, config registers and output register.
// Depends on rbfk_pkg.
module rbfk_datapath #(
	parameter int DIM             = 3,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rbfk_pkg::cmd_t                 cmd,
	output rbfk_pkg::status_t              status,
	input  logic [rbfk_pkg::MAX_DIM-1:0][15:0] a_coord,
	input  logic [rbfk_pkg::MAX_DIM-1:0][15:0] b_coord,
	input  logic                           grad_a,
	input  logic                           grad_b,
	input  logic                           cfg_valid,
	input  logic [rbfk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    entry_value,
	output logic [1:0]                     entry_kind,
	output logic [1:0]                     dim_a,
	output logic [1:0]                     dim_b,
	output logic                           last
);
	import rbfk_pkg::*;

	localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam logic [63:0] EXP_H = (64'd16 << 31) / EXP_TABLE_DEPTH;
	localparam logic [63:0] EXP_B = exp_base(EXP_H);

	// exp(-x) table over [0,16], Q2.30
	logic [30:0] exp_tab [EXP_TABLE_DEPTH+1];
	for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
		localparam logic [30:0] ENT = exp_entry(EXP_B, gi);
		assign exp_tab[gi] = ENT;
	end

	logic [31:0]  alpha_q, inv_q;
	logic [15:0]  dm_q [MAX_DIM];
	logic         dneg_q [MAX_DIM];
	logic         ga_q, gb_q;
	logic [33:0]  r2_q;
	logic [48:0]  xacc_q;
	logic         big_q;
	logic [TW-1:0] idx_q;
	logic [19:0]  f_q;
	logic [30:0]  ta_q, tb_q, e_q;
	logic [31:0]  k_q;
	logic [47:0]  ik_q;
	logic [31:0]  g_q [MAX_DIM];
	logic [31:0]  dd_q;
	logic         ddneg_q;
	logic [48:0]  tmag_q;
	logic         tneg_q;
	logic [31:0]  m_q;
	logic         mneg_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic         ovalid_q;
	logic [31:0]  oval_q;
	logic [1:0]   okind_q, oda_q, odb_q;
	logic         olast_q;

	logic [63:0]  opa, opb;
	logic [31:0]  part_a, part_b;
	logic [127:0] pp_shift;
	logic [49:0]  x_sum;
	logic         x_big;
	logic [30:0]  p_idx;
	logic [TW-1:0] rom_addr;
	logic [63:0]  k_round;
	logic [48:0]  pm_ext, delta;
	logic [48:0]  tmag_d;
	logic         tneg_d;
	logic [31:0]  emit_mag;
	logic         emit_neg;
	logic [1:0]   emit_da, emit_db;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ONE_Q16;
			inv_q   <= ONE_Q16;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ALPHA: alpha_q <= cfg_data;
				CFG_INV:   inv_q   <= cfg_data;
				default:   alpha_q <= alpha_q;
			endcase
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.op)
			OP_SQ:     begin opa = 64'(dm_q[cmd.i]);  opb = 64'(dm_q[cmd.i]); end
			OP_XHI:    begin opa = 64'(inv_q);        opb = 64'(r2_q[33:17]); end
			OP_XLO:    begin opa = 64'(inv_q);        opb = 64'(r2_q[16:0]);  end
			OP_INTERP: begin opa = 64'(ta_q - tb_q);  opb = 64'(f_q);         end
			OP_K:      begin opa = 64'(alpha_q);      opb = 64'(e_q);         end
			OP_IK:     begin opa = 64'(inv_q);        opb = 64'(k_q);         end
			OP_G:      begin opa = 64'(ik_q);         opb = 64'(dm_q[cmd.i]); end
			OP_DD:     begin opa = 64'(dm_q[cmd.i]);  opb = 64'(dm_q[cmd.j]); end
			OP_PM:     begin opa = 64'(inv_q);        opb = 64'(dd_q);        end
			OP_TM:     begin opa = 64'(ik_q);         opb = 64'(tmag_q);      end
			default:   begin opa = '0;                opb = '0;               end
		endcase
		part_a = cmd.part[0] ? opa[63:32] : opa[31:0];
		part_b = cmd.part[1] ? opb[63:32] : opb[31:0];
		case (sh_s1)
			2'd0:    pp_shift = {64'd0, pp_s1};
			2'd1:    pp_shift = {32'd0, pp_s1, 32'd0};
			default: pp_shift = {pp_s1, 64'd0};
		endcase
	end

	// partial product stage, then accumulate
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			pp_s1 <= part_a * part_b;
			sh_s1 <= 2'(cmd.part[0]) + 2'(cmd.part[1]);
		end
		if (cmd.accum) begin
			acc_q <= (cmd.first ? 128'd0 : acc_q) + pp_shift;
		end
	end

	// write-back arithmetic
	always_comb begin
		x_sum    = 50'(xacc_q) + 50'(acc_q[48:17]);
		x_big    = |x_sum[49:20];
		p_idx    = 31'(x_sum[19:0]) * 31'(EXP_TABLE_DEPTH);
		k_round  = acc_q[63:0] + (64'd1 << 29);
		pm_ext   = 49'(acc_q[63:16]);
		delta    = (cmd.i == cmd.j) ? 49'h1_0000 : 49'd0;
		rom_addr = cmd.rom_b ? TW'(idx_q + 1'b1) : idx_q;
		if (ddneg_q) begin
			tmag_d = pm_ext + delta;
			tneg_d = 1'b0;
		end else if (pm_ext > delta) begin
			tmag_d = pm_ext - delta;
			tneg_d = 1'b1;
		end else begin
			tmag_d = delta - pm_ext;
			tneg_d = 1'b0;
		end
	end

	// request load, table reads and write-back registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < MAX_DIM; k++) begin
				logic signed [16:0] dk;
				if (k < DIM) begin
					dk = 17'($signed(a_coord[k])) - 17'($signed(b_coord[k]));
				end else begin
					dk = '0;
				end
				dm_q[k]   <= dk[16] ? 16'(-dk) : dk[15:0];
				dneg_q[k] <= dk[16];
			end
			ga_q <= grad_a;
			gb_q <= grad_b;
			r2_q <= '0;
		end
		if (cmd.rom_a) begin
			ta_q <= exp_tab[rom_addr];
		end
		if (cmd.rom_b) begin
			tb_q <= exp_tab[rom_addr];
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_SQ:  r2_q <= r2_q + acc_q[33:0];
				OP_XHI: xacc_q <= acc_q[48:0];
				OP_XLO: begin
					big_q <= x_big;
					idx_q <= x_big ? '0 : TW'(p_idx[30:20]);
					f_q   <= p_idx[19:0];
				end
				OP_INTERP: e_q <= big_q ? 31'd0 : (ta_q - acc_q[50:20]);
				OP_K:      k_q <= k_round[61:30];
				OP_IK:     ik_q <= acc_q[63:16];
				OP_G: begin
					g_q[cmd.i] <= (|acc_q[127:39]) ? 32'h8000_0000 : {1'b0, acc_q[38:8]};
				end
				OP_DD: begin
					dd_q    <= acc_q[31:0];
					ddneg_q <= (dneg_q[cmd.i] ^ dneg_q[cmd.j]) && (|acc_q[31:0]);
				end
				OP_PM: begin
					tmag_q <= tmag_d;
					tneg_q <= tneg_d;
				end
				OP_TM: begin
					m_q    <= (|acc_q[127:47]) ? 32'h8000_0000 : {1'b0, acc_q[46:16]};
					mneg_q <= tneg_q;
				end
				default: r2_q <= r2_q;
			endcase
		end
	end

	// entry select
	always_comb begin
		case (cmd.kind)
			KIND_VV: begin emit_mag = k_q;        emit_neg = 1'b0;
				emit_da = '0;    emit_db = '0;    end
			KIND_VG: begin emit_mag = g_q[cmd.i]; emit_neg = dneg_q[cmd.i];
				emit_da = '0;    emit_db = cmd.i; end
			KIND_GV: begin emit_mag = g_q[cmd.i]; emit_neg = !dneg_q[cmd.i];
				emit_da = cmd.i; emit_db = '0;    end
			default: begin emit_mag = m_q;        emit_neg = mneg_q;
				emit_da = cmd.i; emit_db = cmd.j; end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			oval_q  <= sat_entry(emit_mag, emit_neg);
			okind_q <= cmd.kind;
			oda_q   <= emit_da;
			odb_q   <= emit_db;
			olast_q <= cmd.last;
		end
	end

	assign status.grad_a   = ga_q;
	assign status.grad_b   = gb_q;
	assign status.out_free = !ovalid_q || !out_stall;

	assign out_valid   = ovalid_q;
	assign entry_value = oval_q;
	assign entry_kind  = okind_q;
	assign dim_a       = oda_q;
	assign dim_b       = odb_q;
	assign last        = olast_q;

endmodule

// ===== design/rbf_kernel_pair_with_gradients.sv =====
// Squared-exponential kernel entries with gradients for one pair of points.
// Request channel: in_valid/in_stall with two Q8.8 points and gradient flags.
// Entry channel: out_valid/out_stall, one Q16.16 entry per transfer, with
// kind, dimensions and a last flag on the final entry of the pair.
// Config: cfg_valid/cfg_ready, index 0 = signal_variance, 1 = inv_length_sq;
// write only while no request is in flight.
// Multiplier: every product goes through one 32x32 multiplier as four partial
// products, issued one after another and summed in an accumulator.
// One request is worked on at a time; in_stall is low only while idle.
// Reset: both registers return to 1.0, the sequencer idles, no entry valid.
// A stalled entry holds in the output register; the sequencer waits for it
// before the next entry, and a new request may be taken while it waits.
// Depends on rbfk_pkg, rbfk_ctrl, rbfk_datapath.
module rbf_kernel_pair_with_gradients #(
	parameter int DIM             = 3,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    a_coord_0,
	input  logic [15:0]                    a_coord_1,
	input  logic [15:0]                    a_coord_2,
	input  logic [15:0]                    b_coord_0,
	input  logic [15:0]                    b_coord_1,
	input  logic [15:0]                    b_coord_2,
	input  logic                           grad_a,
	input  logic                           grad_b,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    entry_value,
	output logic [1:0]                     entry_kind,
	output logic [1:0]                     dim_a,
	output logic [1:0]                     dim_b,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbfk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import rbfk_pkg::*;

	cmd_t    cmd;
	status_t status;

	// registers always take a write
	assign cfg_ready = 1'b1;

	rbfk_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	rbfk_datapath #(
		.DIM            (DIM),
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.a_coord    ({a_coord_2, a_coord_1, a_coord_0}),
		.b_coord    ({b_coord_2, b_coord_1, b_coord_0}),
		.grad_a     (grad_a),
		.grad_b     (grad_b),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.entry_value(entry_value),
		.entry_kind (entry_kind),
		.dim_a      (dim_a),
		.dim_b      (dim_b),
		.last       (last)
	);

endmodule
